// ----- rtl/svm_pkg.sv -----
// ============================================================================
// svm_pkg
// Shared types, codes and defaults for the two-stack instruction execute core.
// ============================================================================
package svm_pkg;

    localparam int OPERAND_DEPTH_DEF = 64;
    localparam int FRAME_DEPTH_DEF   = 64;
    localparam int ADDRESS_BITS_DEF  = 16;
    localparam int ENTRY_W           = 16;

    typedef enum logic [3:0] {
        F_HALT = 4'd0, F_NOP = 4'd1, F_SYMBOL = 4'd2, F_OP = 4'd3,
        F_PUSHC = 4'd4, F_POPC = 4'd5, F_PUSHO = 4'd6, F_POPO = 4'd7,
        F_LOAD = 4'd8, F_SAVE = 4'd9, F_JMP = 4'd10, F_JZ = 4'd11,
        F_JNZ = 4'd12, F_JIP = 4'd13, F_JSIP = 4'd14, F_PRNT = 4'd15
    } t_func;

    localparam logic [3:0] OP_NEG = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2,
        OP_MUL = 4'd3, OP_DIV = 4'd4, OP_MOD = 4'd5, OP_EQ = 4'd6,
        OP_GT = 4'd7, OP_LT = 4'd8, OP_GTE = 4'd9, OP_LTE = 4'd10;

    localparam logic [3:0] FLT_NONE = 4'd0, FLT_OP_UNDER = 4'd1,
        FLT_OP_OVER = 4'd2, FLT_CALL_UNDER = 4'd3, FLT_CALL_OVER = 4'd4,
        FLT_BAD_OFFSET = 4'd5, FLT_BAD_CODE = 4'd6, FLT_DIV_ZERO = 4'd7,
        FLT_JUMP_RANGE = 4'd8;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [63:0] argument;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        next_address;
        logic               halted;
        logic [3:0]         fault;
        logic               print_valid;
        logic signed [63:0] print_value;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic cap;      // capture item, issue stack reads
        logic exec;     // register ALU result and partial products
        logic div_go;   // start divider
        logic commit;   // evaluate and write back
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div; // item is a div or mod that reaches the divider
        logic div_done;
    } t_dp_sts;

endpackage

// ----- rtl/svm_div.sv -----
// ============================================================================
// svm_div
// Iterative unsigned 64-bit divider, one quotient bit per cycle.
// ============================================================================
module svm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic [63:0] r_q, r_r, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] trial;

    assign trial = {r_r, r_q[63]} - {1'b0, r_d};

    // Shift and subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!trial[64]) begin
                    r_r <= trial[63:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= {r_r[62:0], r_q[63]};
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ----- rtl/svm_ctrl.sv -----
// ============================================================================
// svm_ctrl
// Sequencer: capture, read, optional divide, commit, output hold.
// ============================================================================
module svm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output svm_pkg::t_dp_cmd   o_cmd,
    input  svm_pkg::t_dp_sts   i_sts
);
    import svm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_READ = 4'b0010, S_DIV = 4'b0100, S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_div) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/svm_dp.sv -----
// ============================================================================
// svm_dp
// Datapath: both stacks in memories, pointers, instruction pointer, ALU.
// ============================================================================
module svm_dp #(
    parameter int OPERAND_DEPTH = svm_pkg::OPERAND_DEPTH_DEF,
    parameter int FRAME_DEPTH   = svm_pkg::FRAME_DEPTH_DEF,
    parameter int ADDRESS_BITS  = svm_pkg::ADDRESS_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svm_pkg::t_in_item  i_in,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  svm_pkg::t_dp_cmd   i_cmd,
    output svm_pkg::t_dp_sts   o_sts,
    output svm_pkg::t_out_item o_out
);
    import svm_pkg::*;

    localparam int OW = $clog2(OPERAND_DEPTH);
    localparam int FW = $clog2(FRAME_DEPTH);
    localparam int AW = ADDRESS_BITS;

    logic [63:0] r_ostk [OPERAND_DEPTH];
    logic [63:0] r_fstk [FRAME_DEPTH];
    logic [OW:0] r_otop;
    logic [FW:0] r_ftop;
    logic [AW-1:0] r_ip;

    t_in_item    r_item;
    logic [63:0] r_x, r_y, r_fr;     // second, top, frame entry
    logic [63:0] div_quot, div_rem, r_alu;   // signed divider results and fast result
    logic [63:0] mul_prod;
    t_out_item   r_out;

    logic [3:0]  func;
    logic [63:0] arg;
    logic [OW-1:0] rd_top1, rd_top2;
    logic [FW-1:0] rd_frm;

    assign func = r_item.func;
    assign arg  = r_item.argument;

    // Frame read address comes from the item being captured; operand reads from the stack pointer
    logic [FW:0] cap_off;
    assign cap_off = i_in.argument[FW:0];
    assign rd_top1 = OW'(r_otop - (OW+1)'(1));
    assign rd_top2 = OW'(r_otop - (OW+1)'(2));
    assign rd_frm  = FW'(r_ftop - cap_off);

    // Stack reads, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_in;
            r_y    <= r_ostk[rd_top1];
            r_x    <= r_ostk[rd_top2];
            r_fr   <= r_fstk[rd_frm];
        end
    end

    // Divide operands: magnitudes
    logic [63:0] mag_x, mag_y;
    logic        r_div_q_neg, r_div_r_neg;
    logic [63:0] dq, dr;
    logic        ddone;
    assign mag_x = r_x[63] ? (64'd0 - r_x) : r_x;
    assign mag_y = r_y[63] ? (64'd0 - r_y) : r_y;

    svm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_go),
        .i_dividend(mag_x), .i_divisor(mag_y),
        .o_done(ddone), .o_quot(dq), .o_rem(dr)
    );

    // Fast ALU result, registered; multiply registered on its own
    logic        slt_xy, slt_yx;
    logic [63:0] alu_c;
    assign slt_xy = $signed(r_x) < $signed(r_y);
    assign slt_yx = $signed(r_y) < $signed(r_x);
    always_comb begin
        unique case (arg[3:0])
            OP_NEG:  alu_c = 64'd0 - r_y;
            OP_ADD:  alu_c = r_x + r_y;
            OP_SUB:  alu_c = r_x - r_y;
            OP_EQ:   alu_c = {63'd0, r_x == r_y};
            OP_GT:   alu_c = {63'd0, slt_yx};
            OP_LT:   alu_c = {63'd0, slt_xy};
            OP_GTE:  alu_c = {63'd0, !slt_xy};
            OP_LTE:  alu_c = {63'd0, !slt_yx};
            default: alu_c = 64'd0;
        endcase
    end

    // Multiply as three 32x32 partial products over the exec stage
    logic [63:0] p_ll, p_lh, p_hl;
    logic [63:0] r_ll, r_lh, r_hl;
    assign p_ll = r_x[31:0] * r_y[31:0];
    assign p_lh = r_x[31:0] * r_y[63:32];
    assign p_hl = r_x[63:32] * r_y[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_alu       <= alu_c;
            r_ll        <= p_ll;
            r_lh        <= p_lh;
            r_hl        <= p_hl;
            r_div_q_neg <= r_x[63] ^ r_y[63];
            r_div_r_neg <= r_x[63];
        end
    end
    assign mul_prod = r_ll + {r_lh[31:0] + r_hl[31:0], 32'd0};
    assign div_quot = r_div_q_neg ? (64'd0 - dq) : dq;
    assign div_rem  = r_div_r_neg ? (64'd0 - dr) : dr;

    // Decode checks
    logic op_empty, op_full, op_lt2, fr_empty, fr_full;
    logic bad_code, off_bad, ydiv0;
    assign op_empty = (r_otop == '0);
    assign op_lt2   = (r_otop < (OW+1)'(2));
    assign op_full  = (r_otop >= (OW+1)'(OPERAND_DEPTH));
    assign fr_empty = (r_ftop == '0);
    assign fr_full  = (r_ftop >= (FW+1)'(FRAME_DEPTH));
    assign bad_code = (arg > 64'd10);
    assign off_bad  = (arg == 64'd0) || arg[63] || (arg > 64'(r_ftop));
    assign ydiv0    = (r_y == 64'd0);

    assign o_sts.need_div = (func == F_OP) && !op_lt2 && !ydiv0 &&
                            ((arg == 64'(OP_DIV)) || (arg == 64'(OP_MOD)));
    assign o_sts.div_done = ddone;

    // Evaluate the instruction
    logic [3:0]  flt;
    logic        halt, pv, jump, do_jmp;
    logic [63:0] target, res;
    logic [AW-1:0] nip;
    assign nip = r_ip + AW'(1);

    always_comb begin
        flt    = FLT_NONE;
        halt   = 1'b0;
        pv     = 1'b0;
        jump   = 1'b0;
        target = arg;
        unique case (t_func'(func))
            F_HALT: halt = 1'b1;
            F_NOP, F_SYMBOL: ;
            F_OP: begin
                if (bad_code) flt = FLT_BAD_CODE;
                else if (arg == 64'(OP_NEG)) begin
                    if (op_empty) flt = FLT_OP_UNDER;
                end else if (op_lt2) flt = FLT_OP_UNDER;
                else if (((arg == 64'(OP_DIV)) || (arg == 64'(OP_MOD))) && ydiv0)
                    flt = FLT_DIV_ZERO;
            end
            F_PUSHC, F_JSIP: begin
                if (fr_full) flt = FLT_CALL_OVER;
                else jump = (func == F_JSIP);
            end
            F_POPC:  if (fr_empty) flt = FLT_CALL_UNDER;
            F_PUSHO: if (op_full) flt = FLT_OP_OVER;
            F_POPO:  if (op_empty) flt = FLT_OP_UNDER;
            F_LOAD: begin
                if (off_bad) flt = FLT_BAD_OFFSET;
                else if (op_full) flt = FLT_OP_OVER;
            end
            F_SAVE: begin
                if (op_empty) flt = FLT_OP_UNDER;
                else if (off_bad) flt = FLT_BAD_OFFSET;
            end
            F_JMP: jump = 1'b1;
            F_JZ, F_JNZ: begin
                if (op_empty) flt = FLT_OP_UNDER;
                else jump = ((func == F_JZ) == ydiv0);
            end
            F_JIP: begin
                if (op_empty) flt = FLT_OP_UNDER;
                else begin
                    jump   = 1'b1;
                    target = r_y;
                end
            end
            F_PRNT: begin
                if (op_empty) flt = FLT_OP_UNDER;
                else pv = 1'b1;
            end
            default: ;
        endcase
        if (flt == FLT_NONE && jump && (target > 64'((65'd1 << AW) - 65'd1)))
            flt = FLT_JUMP_RANGE;
        do_jmp = jump && (flt == FLT_NONE);
        unique case (arg[3:0])
            OP_MUL:  res = mul_prod;
            OP_DIV:  res = div_quot;
            OP_MOD:  res = div_rem;
            default: res = r_alu;
        endcase
    end

    // Commit: write back stacks, pointers, result register
    logic ok;
    assign ok = (flt == FLT_NONE);
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && ok) begin
            unique case (t_func'(func))
                F_OP: begin
                    if (arg == 64'(OP_NEG)) r_ostk[rd_top1] <= res;
                    else r_ostk[rd_top2] <= res;
                end
                F_PUSHO: r_ostk[OW'(r_otop)] <= arg;
                F_LOAD:  r_ostk[OW'(r_otop)] <= r_fr;
                F_PUSHC: r_fstk[FW'(r_ftop)] <= arg;
                F_JSIP:  r_fstk[FW'(r_ftop)] <= 64'(nip);
                F_SAVE:  r_fstk[FW'(r_ftop - arg[FW:0])] <= r_y;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otop <= '0;
            r_ftop <= '0;
            r_ip   <= '0;
        end else if (i_cfg_we) begin
            r_ip <= AW'(i_cfg_data);
        end else if (i_cmd.commit && ok) begin
            r_ip <= do_jmp ? AW'(target) : nip;
            unique case (t_func'(func))
                F_OP: if (arg != 64'(OP_NEG)) r_otop <= r_otop - (OW+1)'(1);
                F_PUSHO, F_LOAD: r_otop <= r_otop + (OW+1)'(1);
                F_POPO, F_SAVE, F_JZ, F_JNZ: r_otop <= r_otop - (OW+1)'(1);
                F_JIP: r_otop <= r_otop - (OW+1)'(1);
                F_PUSHC, F_JSIP: r_ftop <= r_ftop + (FW+1)'(1);
                F_POPC: r_ftop <= r_ftop - (FW+1)'(1);
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.next_address <= 16'(ok ? (do_jmp ? AW'(target) : nip) : r_ip);
            r_out.halted       <= halt || !ok;
            r_out.fault        <= flt;
            r_out.print_valid  <= pv && ok;
            r_out.print_value  <= (pv && ok) ? r_y : 64'd0;
        end
    end

    assign o_out = r_out;
endmodule

// ----- rtl/stack_vm_instruction_execute_core.sv -----
// ============================================================================
// stack_vm_instruction_execute_core
// Executes one instruction per input transfer on an operand and a call stack.
// ============================================================================
//  channel | direction | handshake        | payload
//  in      | input     | valid / stall    | func, argument
//  out     | output    | valid / stall    | next_address, halted, fault, print
//  cfg     | input     | valid / ready    | entry_address
//
//  An instruction runs through capture with stack reads, execute, commit.
//  div and mod add a pass through the bit-serial divider.
//  Reset clears both stack pointers and the instruction pointer; no clearing pass.
//  A stalled output holds the commit step; one result waits in the output register.
// ============================================================================
module stack_vm_instruction_execute_core #(
    parameter int OPERAND_DEPTH = svm_pkg::OPERAND_DEPTH_DEF,
    parameter int FRAME_DEPTH   = svm_pkg::FRAME_DEPTH_DEF,
    parameter int ADDRESS_BITS  = svm_pkg::ADDRESS_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  svm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output svm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import svm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    svm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cmd(cmd), .i_sts(sts)
    );

    svm_dp #(
        .OPERAND_DEPTH(OPERAND_DEPTH), .FRAME_DEPTH(FRAME_DEPTH),
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in_data),
        .i_cfg_we(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_sts(sts), .o_out(o_out_data)
    );

`ifndef NO_ASSERTIONS
    // Only one command of the sequencer fires in a cycle besides exec with div_go
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.cap, cmd.exec, cmd.commit}) <= 1)
        else $error("multiple sequencer commands");
    // A commit always presents a result next cycle
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("commit without result");
    // A capture is not followed at once by another capture
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cap |=> !cmd.cap)
        else $error("capture overlap");
`endif
endmodule
